/* design/eu8wd_pkg.sv */
// Package with the shared types and constants of the extended UTF-8 window decoder.
`timescale 1ns / 1ps
package eu8wd_pkg;

   localparam int unsigned CP_W    = 31;
   localparam int unsigned LEN_W   = 3;
   localparam int unsigned ST_W    = 3;
   localparam int unsigned AVAIL_W = 3;
   localparam int unsigned IDX_W   = 2;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_SHORT   = 3'd1;
   localparam logic [ST_W-1:0] ST_BADBYTE = 3'd2;
   localparam logic [ST_W-1:0] ST_OOB     = 3'd3;
   localparam logic [ST_W-1:0] ST_BADCP   = 3'd4;

   localparam logic [IDX_W-1:0] REG_MAX_CP    = 2'd0;
   localparam logic [IDX_W-1:0] REG_TRAP_LOW  = 2'd1;
   localparam logic [IDX_W-1:0] REG_TRAP_HIGH = 2'd2;
   localparam logic [IDX_W-1:0] REG_SENTINEL  = 2'd3;

   localparam logic [CP_W-1:0] MAX_CP_RESET    = 31'h7FFF_FFFF;
   localparam logic [CP_W-1:0] TRAP_LOW_RESET  = 31'h7FFF_FFFE;
   localparam logic [CP_W-1:0] TRAP_HIGH_RESET = 31'h7FFF_FFFE;
   localparam logic [CP_W-1:0] SENTINEL_RESET  = 31'h7FFF_FFFF;

   localparam logic [CP_W-1:0] MIN_CP_2 = 31'h0000_0080;
   localparam logic [CP_W-1:0] MIN_CP_3 = 31'h0000_0800;
   localparam logic [CP_W-1:0] MIN_CP_4 = 31'h0001_0000;
   localparam logic [CP_W-1:0] MAX_CP_4 = 31'h0010_FFFF;
   localparam logic [CP_W-1:0] MIN_CP_5 = 31'h0011_0000;
   localparam logic [CP_W-1:0] MAX_CP_5 = 31'h03FF_FFFF;
   localparam logic [CP_W-1:0] MIN_CP_6 = 31'h0400_0000;

   typedef struct packed {
      logic [7:0]         byte_0;
      logic [7:0]         byte_1;
      logic [7:0]         byte_2;
      logic [7:0]         byte_3;
      logic [7:0]         byte_4;
      logic [7:0]         byte_5;
      logic [AVAIL_W-1:0] bytes_available;
   } eu8wd_req_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] bytes_consumed;
      logic [ST_W-1:0]  status;
   } eu8wd_rsp_type;

   // Lead byte decode result handed from the first stage to the rest of the pipe.
   typedef struct packed {
      logic             valid;
      logic             early_err;
      logic [ST_W-1:0]  early_status;
      logic [LEN_W-1:0] len;
      logic [7:0]       lead;
      logic [4:0][5:0]  cont;
   } eu8wd_s1_type;

endpackage

/* design/extended_utf8_window_decoder.sv */
// Top level of the extended UTF-8 window decoder: four stage pipeline and control registers.
`timescale 1ns / 1ps
//
//  Channel   Ports                           Handshake
//  -------   -----------------------------   ---------------------------------------
//  request   start, busy, req_data           taken when start is high and busy is low
//  response  rsp_valid, rsp_data             one cycle strobe, cannot be held off
//  control   csr_we, csr_index, csr_wdata    written when csr_we is high
//
// Every transaction passes from start to rsp_valid through the four register stages
// (lead decode, code point assembly, range compares, status select). A new transaction is
// taken in every cycle, so busy stays low. Reset clears the valid bits of all stages and
// restores the control registers; the response side never stalls the pipe.
module extended_utf8_window_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  eu8wd_pkg::eu8wd_req_type     req_data,
   output logic                         rsp_valid,
   output eu8wd_pkg::eu8wd_rsp_type     rsp_data,
   input  logic                         csr_we,
   input  logic [eu8wd_pkg::IDX_W-1:0]  csr_index,
   input  logic [eu8wd_pkg::CP_W-1:0]   csr_wdata
);
   import eu8wd_pkg::*;

   typedef struct packed {
      logic             valid;
      logic             early_err;
      logic [ST_W-1:0]  early_status;
      logic [LEN_W-1:0] len;
      logic [CP_W-1:0]  cp;
   } eu8wd_s2_type;

   typedef struct packed {
      logic             valid;
      logic             early_err;
      logic [ST_W-1:0]  early_status;
      logic [LEN_W-1:0] len;
      logic [CP_W-1:0]  cp;
      logic             gt_max;
      logic             low_bad;
      logic             in_trap;
      logic             eq_sentinel;
   } eu8wd_s3_type;

   logic [CP_W-1:0] max_cp_ff;
   logic [CP_W-1:0] trap_low_ff;
   logic [CP_W-1:0] trap_high_ff;
   logic [CP_W-1:0] sentinel_ff;

   eu8wd_s1_type  s1;
   eu8wd_s2_type  s2_ff;
   eu8wd_s2_type  s2_in;
   eu8wd_s3_type  s3_ff;
   eu8wd_s3_type  s3_in;
   logic          out_valid_ff;
   eu8wd_rsp_type out_data_ff;
   eu8wd_rsp_type out_data_in;
   logic          is_six;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cp_ff    <= MAX_CP_RESET;
         trap_low_ff  <= TRAP_LOW_RESET;
         trap_high_ff <= TRAP_HIGH_RESET;
         sentinel_ff  <= SENTINEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_CP:    max_cp_ff    <= csr_wdata;
            REG_TRAP_LOW:  trap_low_ff  <= csr_wdata;
            REG_TRAP_HIGH: trap_high_ff <= csr_wdata;
            REG_SENTINEL:  sentinel_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   eu8wd_lead_decode u_lead_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_stage (s1)
   );

   always_comb begin
      s2_in.valid        = s1.valid;
      s2_in.early_err    = s1.early_err;
      s2_in.early_status = s1.early_status;
      s2_in.len          = s1.len;
      case (s1.len)
         3'd1: s2_in.cp = {24'd0, s1.lead[6:0]};
         3'd2: s2_in.cp = {20'd0, s1.lead[4:0], s1.cont[0]};
         3'd3: s2_in.cp = {15'd0, s1.lead[3:0], s1.cont[0], s1.cont[1]};
         3'd4: s2_in.cp = {10'd0, s1.lead[2:0], s1.cont[0], s1.cont[1], s1.cont[2]};
         3'd5: s2_in.cp = {5'd0, s1.lead[1:0], s1.cont[0], s1.cont[1], s1.cont[2],
                           s1.cont[3]};
         3'd6: s2_in.cp = {s1.lead[0], s1.cont[0], s1.cont[1], s1.cont[2], s1.cont[3],
                           s1.cont[4]};
         default: s2_in.cp = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   always_comb begin
      is_six             = (s2_ff.len == 3'd6);
      s3_in.valid        = s2_ff.valid;
      s3_in.early_err    = s2_ff.early_err;
      s3_in.early_status = s2_ff.early_status;
      s3_in.len          = s2_ff.len;
      s3_in.cp           = s2_ff.cp;
      s3_in.gt_max       = is_six && (s2_ff.cp > max_cp_ff);
      s3_in.in_trap      = is_six && (s2_ff.cp >= trap_low_ff) && (s2_ff.cp <= trap_high_ff);
      s3_in.eq_sentinel  = is_six && (s2_ff.cp == sentinel_ff);
      case (s2_ff.len)
         3'd2:    s3_in.low_bad = (s2_ff.cp < MIN_CP_2);
         3'd3:    s3_in.low_bad = (s2_ff.cp < MIN_CP_3);
         3'd4:    s3_in.low_bad = (s2_ff.cp < MIN_CP_4) || (s2_ff.cp > MAX_CP_4);
         3'd5:    s3_in.low_bad = (s2_ff.cp < MIN_CP_5) || (s2_ff.cp > MAX_CP_5);
         3'd6:    s3_in.low_bad = (s2_ff.cp < MIN_CP_6);
         default: s3_in.low_bad = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
      end else begin
         s3_ff <= s3_in;
      end
   end

   always_comb begin
      out_data_in.code_point     = '0;
      out_data_in.bytes_consumed = '0;
      if (s3_ff.early_err) begin
         out_data_in.status = s3_ff.early_status;
      end else if (s3_ff.gt_max) begin
         out_data_in.status = ST_OOB;
      end else if (s3_ff.low_bad) begin
         out_data_in.status = ST_BADBYTE;
      end else if (s3_ff.in_trap || s3_ff.eq_sentinel) begin
         out_data_in.status = ST_BADCP;
      end else begin
         out_data_in.status         = ST_OK;
         out_data_in.code_point     = s3_ff.cp;
         out_data_in.bytes_consumed = s3_ff.len;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_ff.valid;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("Accepted transaction did not produce a response after four cycles.");

   a_len_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status == ST_OK) == (rsp_data.bytes_consumed != 3'd0)))
      else $error("Response length does not agree with its status.");

   a_error_zero_cp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.code_point == '0))
      else $error("Failed transaction returned a nonzero code point.");

   a_single_byte_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.bytes_consumed == 3'd1)) |-> (rsp_data.code_point < MIN_CP_2))
      else $error("Single byte transaction returned a code point above seven bits.");

endmodule

/* design/eu8wd_lead_decode.sv */
// First pipeline stage: lead byte decode, window length check and continuation byte check.
`timescale 1ns / 1ps
module eu8wd_lead_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  eu8wd_pkg::eu8wd_req_type in_data,
   output eu8wd_pkg::eu8wd_s1_type  out_stage
);
   import eu8wd_pkg::*;

   eu8wd_s1_type     stage_ff;
   eu8wd_s1_type     stage_in;
   logic [AVAIL_W-1:0] avail;
   logic [LEN_W-1:0] len;
   logic             lead_ok;
   logic [5:0][7:0]  bytes;
   logic             cont_bad;

   assign bytes = {in_data.byte_5, in_data.byte_4, in_data.byte_3,
                   in_data.byte_2, in_data.byte_1, in_data.byte_0};

   always_comb begin
      avail = (in_data.bytes_available == 3'd7) ? 3'd6 : in_data.bytes_available;
      lead_ok = 1'b1;
      if (in_data.byte_0[7] == 1'b0) begin
         len = 3'd1;
      end else if (in_data.byte_0[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (in_data.byte_0[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (in_data.byte_0[7:3] == 5'b11110) begin
         len = 3'd4;
      end else if (in_data.byte_0[7:2] == 6'b111110) begin
         len = 3'd5;
      end else if (in_data.byte_0[7:1] == 7'b1111110) begin
         len = 3'd6;
      end else begin
         len = 3'd0;
         lead_ok = 1'b0;
      end
   end

   always_comb begin
      cont_bad = 1'b0;
      for (int i = 1; i < 6; i++) begin
         if ((LEN_W'(i) < len) && (bytes[i][7:6] != 2'b10)) begin
            cont_bad = 1'b1;
         end
      end
   end

   always_comb begin
      stage_in.valid        = in_valid;
      stage_in.len          = len;
      stage_in.lead         = in_data.byte_0;
      for (int i = 0; i < 5; i++) begin
         stage_in.cont[i] = bytes[i+1][5:0];
      end
      stage_in.early_err    = 1'b1;
      stage_in.early_status = ST_OK;
      if (avail == 3'd0) begin
         stage_in.early_status = ST_SHORT;
      end else if (!lead_ok) begin
         stage_in.early_status = ST_BADBYTE;
      end else if (avail < len) begin
         stage_in.early_status = ST_SHORT;
      end else if (cont_bad) begin
         stage_in.early_status = ST_BADBYTE;
      end else begin
         stage_in.early_err = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule
